// ===== hdl/lbt_pkg.sv =====
// ----------------------------------------------------------------------------
// lbt_pkg
// Shared types, constants and the LFSR step function of the LED blink/twinkle core.
// ----------------------------------------------------------------------------
package lbt_pkg;

   localparam int NUM_LEDS_DEFAULT = 20;
   localparam int PATTERN_W        = 20;
   localparam int COUNT_W          = 16;
   localparam int LFSR_W           = 16;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [LFSR_W-1:0]  LFSR_SEED = 16'h1234;

   typedef enum logic [1:0] {
      MODE_OFF     = 2'd0,
      MODE_ON      = 2'd1,
      MODE_BLINK   = 2'd2,
      MODE_TWINKLE = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EFFECT_MODE      = 2'd0,
      CSR_BLINK_INTERVAL   = 2'd1,
      CSR_TWINKLE_INTERVAL = 2'd2,
      CSR_RANDOM_THRESHOLD = 2'd3
   } csr_index_type;

   localparam logic [COUNT_W-1:0] BLINK_INTERVAL_RESET   = 16'd50;
   localparam logic [COUNT_W-1:0] TWINKLE_INTERVAL_RESET = 16'd10;
   localparam logic [LFSR_W-1:0]  THRESHOLD_RESET        = 16'd32768;

   typedef struct packed {
      mode_type             effect_mode;
      logic [COUNT_W-1:0]   blink_interval;
      logic [COUNT_W-1:0]   twinkle_interval;
      logic [LFSR_W-1:0]    random_threshold;
   } cfg_type;

   typedef struct packed {
      logic [PATTERN_W-1:0] led_pattern;
      logic [COUNT_W-1:0]   frame_position;
   } rsp_data_type;

   // Fibonacci step: taps 0, 2, 3, 5 fed back into the top bit
   function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
      logic fb;
      fb = v[0] ^ v[2] ^ v[3] ^ v[5];
      return {fb, v[LFSR_W-1:1]};
   endfunction

endpackage

// ===== hdl/lbt_if.sv =====
// ----------------------------------------------------------------------------
// lbt_if
// Valid/ready channel interfaces for frame events and pattern results.
// ----------------------------------------------------------------------------
interface lbt_req_if;
   logic valid;
   logic ready;
   logic frame_tick;

   modport source (output valid, output frame_tick, input ready);
   modport sink   (input valid, input frame_tick, output ready);
endinterface

interface lbt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lbt_pkg::PATTERN_W-1:0]   led_pattern;
   logic [lbt_pkg::COUNT_W-1:0]     frame_position;

   modport source (output valid, output led_pattern, output frame_position, input ready);
   modport sink   (input valid, input led_pattern, input frame_position, output ready);
endinterface

// ===== hdl/led_blink_twinkle_pattern_core.sv =====
// ----------------------------------------------------------------------------
// led_blink_twinkle_pattern_core
// LED pattern generator with off, on, blink and LFSR twinkle effects.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one frame event per item (frame_tick = 1 advances the
//   frame counter, 0 only re-evaluates). Each item yields exactly one result
//   item on rsp_if: the LED pattern and the frame counter after the update.
//   csr_we/csr_index/csr_wdata write the mode, intervals and threshold;
//   write them only while no item is in flight.
//   Each result is registered before it appears on rsp_if.
//   Throughput: one item per cycle while req_if.ready is high; all mode
//   logic, including the NUM_LEDS (twenty by default) chained LFSR steps, is
//   combinational between the state registers and the result register.
//   Reset clears the counter and pattern, reseeds the LFSR to 0x1234 and
//   loads the register defaults; no result is pending afterward.
//   When the receiver stalls, the pending result holds and one more item is
//   taken into a skid register; req_if.ready then drops until the receiver
//   takes a result.
// ----------------------------------------------------------------------------
module led_blink_twinkle_pattern_core #(
   parameter int NUM_LEDS = lbt_pkg::NUM_LEDS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   lbt_req_if.sink                            req_if,
   lbt_rsp_if.source                          rsp_if,
   input  logic                               csr_we,
   input  logic [lbt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lbt_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   lbt_pkg::cfg_type      cfg;
   lbt_pkg::rsp_data_type result;
   logic                  can_push;
   logic                  item_take;

   assign req_if.ready = can_push;
   assign item_take    = req_if.valid && can_push;

   lbt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lbt_engine #(
      .NUM_LEDS (NUM_LEDS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_take  (item_take),
      .frame_tick (req_if.frame_tick),
      .result     (result)
   );

   lbt_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (item_take),
      .push_data (result),
      .can_push  (can_push),
      .rsp_if    (rsp_if)
   );

endmodule

// ===== hdl/lbt_csr.sv =====
// ----------------------------------------------------------------------------
// lbt_csr
// Configuration registers: effect mode, intervals and twinkle threshold.
// ----------------------------------------------------------------------------
module lbt_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [lbt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lbt_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output lbt_pkg::cfg_type                   cfg
);

   lbt_pkg::cfg_type cfg_ff;
   lbt_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (lbt_pkg::csr_index_type'(csr_index))
            lbt_pkg::CSR_EFFECT_MODE:
               cfg_in.effect_mode = lbt_pkg::mode_type'(csr_wdata[1:0]);
            lbt_pkg::CSR_BLINK_INTERVAL:
               cfg_in.blink_interval = csr_wdata[lbt_pkg::COUNT_W-1:0];
            lbt_pkg::CSR_TWINKLE_INTERVAL:
               cfg_in.twinkle_interval = csr_wdata[lbt_pkg::COUNT_W-1:0];
            lbt_pkg::CSR_RANDOM_THRESHOLD:
               cfg_in.random_threshold = csr_wdata[lbt_pkg::LFSR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.effect_mode      <= lbt_pkg::MODE_OFF;
         cfg_ff.blink_interval   <= lbt_pkg::BLINK_INTERVAL_RESET;
         cfg_ff.twinkle_interval <= lbt_pkg::TWINKLE_INTERVAL_RESET;
         cfg_ff.random_threshold <= lbt_pkg::THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/lbt_engine.sv =====
// ----------------------------------------------------------------------------
// lbt_engine
// Frame counter, LED state and LFSR; applies the effect mode per item.
// ----------------------------------------------------------------------------
module lbt_engine #(
   parameter int NUM_LEDS = lbt_pkg::NUM_LEDS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lbt_pkg::cfg_type       cfg,
   input  logic                   item_take,
   input  logic                   frame_tick,
   output lbt_pkg::rsp_data_type  result
);

   localparam int EXT_W = (NUM_LEDS > lbt_pkg::PATTERN_W) ? NUM_LEDS : lbt_pkg::PATTERN_W;
   localparam logic [NUM_LEDS-1:0] LED_MASK = {NUM_LEDS{1'b1}};

   logic [lbt_pkg::COUNT_W-1:0] count_ff, count_in, count_adv;
   logic [NUM_LEDS-1:0]         led_ff, led_in, twinkle_toggle;
   logic [lbt_pkg::LFSR_W-1:0]  lfsr_ff, lfsr_in;
   logic [lbt_pkg::LFSR_W-1:0]  lfsr_chain [0:NUM_LEDS];
   logic [EXT_W-1:0]            led_ext;

   // one LFSR step per LED, LED 0 first; plain XOR wiring
   assign lfsr_chain[0] = lfsr_ff;
   for (genvar i = 0; i < NUM_LEDS; i++) begin : g_led
      assign lfsr_chain[i+1]   = lbt_pkg::lfsr_step(lfsr_chain[i]);
      assign twinkle_toggle[i] = lfsr_chain[i+1] > cfg.random_threshold;
   end

   always_comb begin
      count_adv = count_ff;
      if (frame_tick && count_ff != lbt_pkg::COUNT_MAX)
         count_adv = count_ff + 1'b1;

      count_in = count_adv;
      led_in   = led_ff;
      lfsr_in  = lfsr_ff;
      case (cfg.effect_mode)
         lbt_pkg::MODE_OFF: begin
            led_in   = '0;
            count_in = '0;
         end
         lbt_pkg::MODE_ON: begin
            led_in   = LED_MASK;
            count_in = '0;
         end
         lbt_pkg::MODE_BLINK: begin
            // full period check is 17 bits wide so twice the interval never wraps
            if ({1'b0, count_adv} >= {cfg.blink_interval, 1'b0})
               count_in = '0;
            else if (count_adv >= cfg.blink_interval)
               led_in = LED_MASK;
            else
               led_in = '0;
         end
         lbt_pkg::MODE_TWINKLE: begin
            if (count_adv >= cfg.twinkle_interval) begin
               count_in = '0;
               led_in   = led_ff ^ twinkle_toggle;
               lfsr_in  = lfsr_chain[NUM_LEDS];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         led_ff   <= '0;
         lfsr_ff  <= lbt_pkg::LFSR_SEED;
      end else if (item_take) begin
         count_ff <= count_in;
         led_ff   <= led_in;
         lfsr_ff  <= lfsr_in;
      end
   end

   assign led_ext               = EXT_W'(led_in);
   assign result.led_pattern    = led_ext[lbt_pkg::PATTERN_W-1:0];
   assign result.frame_position = count_in;

endmodule

// ===== hdl/lbt_rsp_buf.sv =====
// ----------------------------------------------------------------------------
// lbt_rsp_buf
// Result register with a skid stage, so the input side stays open while
// one result waits.
// ----------------------------------------------------------------------------
module lbt_rsp_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lbt_pkg::rsp_data_type  push_data,
   output logic                   can_push,
   lbt_rsp_if.source              rsp_if
);

   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   lbt_pkg::rsp_data_type out_data_ff, out_data_in;
   lbt_pkg::rsp_data_type skid_data_ff, skid_data_in;
   logic                  pop;

   assign pop      = out_valid_ff && rsp_if.ready;
   assign can_push = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            // output still held by the receiver: park the item
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.led_pattern    = out_data_ff.led_pattern;
   assign rsp_if.frame_position = out_data_ff.frame_position;

endmodule

// ===== hdl/lbt_checker.sv =====
// ----------------------------------------------------------------------------
// lbt_checker
// Port-level checks of the pattern core, bound to the top level.
// ----------------------------------------------------------------------------
module lbt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [lbt_pkg::PATTERN_W-1:0]     led_pattern,
   input logic [lbt_pkg::COUNT_W-1:0]       frame_position
);

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // an item taken while the output is empty shows up on the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !rsp_valid) |=> rsp_valid)
      else $error("result missing one cycle after item");

   // input side closes only after a stalled result
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(rsp_valid && !rsp_ready))
      else $error("req ready dropped without output stall");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(led_pattern) && $stable(frame_position)))
      else $error("stalled result changed");

endmodule

bind led_blink_twinkle_pattern_core lbt_checker u_lbt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .led_pattern    (rsp_if.led_pattern),
   .frame_position (rsp_if.frame_position)
);
